>>> sv/wmfa_pkg.sv
// Shared types, constants and a helper function of the wide-mantissa float ALU.
package wmfa_pkg;

	localparam int EXP_W        = 16;
	localparam int MANT_W       = 64;
	localparam int OP_W         = 4;
	localparam int ST_W         = 2;
	localparam int QUO_W        = 2 * MANT_W;
	localparam int DIV_STEPS    = QUO_W;
	localparam int LZ_W         = $clog2(MANT_W + 1);
	localparam int SH_W         = $clog2(MANT_W);
	localparam int QLZ_W        = $clog2(QUO_W + 1);
	localparam int FRONT_STAGES = 5;
	localparam int TAIL_DLY     = DIV_STEPS + 1 - FRONT_STAGES;

	localparam logic [OP_W-1:0] OP_ADD   = OP_W'(0);
	localparam logic [OP_W-1:0] OP_SUB   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_MUL   = OP_W'(2);
	localparam logic [OP_W-1:0] OP_DIV   = OP_W'(3);
	localparam logic [OP_W-1:0] OP_LT    = OP_W'(4);
	localparam logic [OP_W-1:0] OP_LE    = OP_W'(5);
	localparam logic [OP_W-1:0] OP_GT    = OP_W'(6);
	localparam logic [OP_W-1:0] OP_GE    = OP_W'(7);
	localparam logic [OP_W-1:0] OP_TRUNC = OP_W'(8);

	localparam logic [ST_W-1:0] ST_NORMAL = ST_W'(0);
	localparam logic [ST_W-1:0] ST_INF    = ST_W'(1);
	localparam logic [ST_W-1:0] ST_NAN    = ST_W'(2);

	typedef struct packed {
		logic [OP_W-1:0]          opcode;
		logic signed [EXP_W-1:0]  a_exponent;
		logic signed [MANT_W-1:0] a_mantissa;
		logic signed [EXP_W-1:0]  b_exponent;
		logic signed [MANT_W-1:0] b_mantissa;
	} in_beat_t;

	typedef struct packed {
		logic signed [EXP_W-1:0]  r_exponent;
		logic signed [MANT_W-1:0] r_mantissa;
		logic                     compare_true;
		logic [ST_W-1:0]          status;
		logic                     special_sign;
	} out_beat_t;

	typedef struct packed {
		logic [MANT_W-1:0] rem;
		logic [MANT_W-1:0] dvs;
		logic [QUO_W-1:0]  qd;
	} div_t;

	typedef struct packed {
		logic             use_div;
		logic             div_neg;
		logic [EXP_W-1:0] div_exp;
		out_beat_t        res;
	} tail_t;

	function automatic logic [LZ_W-1:0] clz_mant(input logic [MANT_W-1:0] x);
		logic [LZ_W-1:0] n;
		n = LZ_W'(MANT_W);
		for (int i = 0; i < MANT_W; i++) begin
			if (x[i]) begin
				n = LZ_W'(MANT_W - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

>>> sv/wide_mantissa_float_alu_core.sv
// Top level of the wide-mantissa float ALU: front pipeline, divider chain and back end.
//
// Fully pipelined ALU for a float made of a 16-bit signed exponent and a signed
// 64-bit mantissa with its leading one at bit 62. It takes one beat per clock
// cycle on req while the output is not stalled and returns one result beat per
// request on rsp, in order. Every opcode (add, subtract, multiply, divide, the
// four compares and truncate) travels a path of the same length, through the
// front section, the divider chain or its matching delay line, the back end
// and the output register. The length is set by the divider: a chain of 128
// restoring-division stages, one quotient bit per stage, which lets a new
// divide enter every cycle while the output is not stalled. Add/sub and
// multiply finish in a five-stage front section and ride a matching delay
// line; two more stages normalize the quotient and pick the result. The whole
// pipeline advances when the output register is empty or being read, so a
// stall holds every stage in place and no beat is lost or repeated. Divide by
// zero returns a zero value with status 1 (infinity, sign of the dividend), and
// zero by zero returns status 2 (NaN). There is no configuration and no clearing period after reset.
module wide_mantissa_float_alu_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  wmfa_pkg::in_beat_t   req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output wmfa_pkg::out_beat_t  rsp
);
	localparam int STEPS = wmfa_pkg::DIV_STEPS;
	localparam int DLY   = wmfa_pkg::TAIL_DLY;
	// Stages before the output register: one front stage feeding the
	// divider, the divider chain, and the first back-end stage.
	localparam int NSTG  = STEPS + 2;

	logic                en;
	logic [NSTG-1:0]     stg_vld_q;
	logic                rsp_valid_q;
	wmfa_pkg::out_beat_t rsp_q;

	// The pipeline moves as a whole whenever the result register can take
	// a new beat.
	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			stg_vld_q   <= {stg_vld_q[NSTG-2:0], req_valid};
			rsp_valid_q <= stg_vld_q[NSTG-1];
		end
	end

	wmfa_pkg::tail_t front_tail;
	wmfa_pkg::div_t  div_chain [STEPS+1];

	wmfa_front u_front (
		.clk      (clk),
		.en       (en),
		.req      (req),
		.tail     (front_tail),
		.div_init (div_chain[0])
	);

	// Divider chain: each stage retires one quotient bit.
	for (genvar g = 0; g < STEPS; g++) begin : g_div
		wmfa_div_step u_step (
			.clk   (clk),
			.en    (en),
			.stin  (div_chain[g]),
			.stout (div_chain[g+1])
		);
	end

	// Results that are final after the front section wait here so that they
	// meet the quotient of the same beat at the back end.
	wmfa_pkg::tail_t tail_dly_q [DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			tail_dly_q[0] <= front_tail;
			for (int k = 1; k < DLY; k++) begin
				tail_dly_q[k] <= tail_dly_q[k-1];
			end
		end
	end

	wmfa_pkg::out_beat_t back_res;

	wmfa_back u_back (
		.clk     (clk),
		.en      (en),
		.div_in  (div_chain[STEPS]),
		.tail_in (tail_dly_q[DLY-1]),
		.result  (back_res)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q <= back_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> sv/wmfa_div_step.sv
// One registered restoring-division step: one quotient bit per stage.
module wmfa_div_step (
	input  logic           clk,
	input  logic           en,
	input  wmfa_pkg::div_t stin,
	output wmfa_pkg::div_t stout
);
	localparam int MW = wmfa_pkg::MANT_W;
	localparam int QW = wmfa_pkg::QUO_W;

	logic [MW:0]   r2;
	logic [MW:0]   diff;
	logic          ge;
	wmfa_pkg::div_t nxt;
	wmfa_pkg::div_t st_q;

	always_comb begin
		r2        = {stin.rem, stin.qd[QW-1]};
		diff      = r2 - {1'b0, stin.dvs};
		ge        = r2 >= {1'b0, stin.dvs};
		nxt.dvs   = stin.dvs;
		nxt.rem   = ge ? diff[MW-1:0] : r2[MW-1:0];
		nxt.qd    = {stin.qd[QW-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
		end
	end

	assign stout = st_q;

endmodule

>>> sv/wmfa_front.sv
// Front pipeline: decode, compare, truncate, add/sub, multiply and divide setup over five stages.
module wmfa_front (
	input  logic               clk,
	input  logic               en,
	input  wmfa_pkg::in_beat_t req,
	output wmfa_pkg::tail_t    tail,
	output wmfa_pkg::div_t     div_init
);
	localparam int MW     = wmfa_pkg::MANT_W;
	localparam int EW     = wmfa_pkg::EXP_W;
	localparam int SW     = wmfa_pkg::SH_W;
	localparam int LW     = wmfa_pkg::LZ_W;
	localparam int QW     = wmfa_pkg::QUO_W;
	localparam int HL     = MW / 2;
	localparam int HH     = MW - HL;
	localparam int PLL_W  = 2 * HL;
	localparam int PMID_W = HL + HH;
	localparam int PHH_W  = 2 * HH;

	localparam logic [1:0] SEL_FIX = 2'd0;
	localparam logic [1:0] SEL_ADD = 2'd1;
	localparam logic [1:0] SEL_MUL = 2'd2;
	localparam logic [1:0] SEL_DIV = 2'd3;

	// Ordering of two values; negatives with a larger exponent are smaller.
	function automatic logic cmp_core(input logic [EW-1:0] xe, input logic [MW-1:0] xm,
		input logic [EW-1:0] ye, input logic [MW-1:0] ym, input logic strict);
		logic xn;
		logic yn;
		logic mlt;
		logic mle;
		logic r;
		xn  = xm[MW-1];
		yn  = ym[MW-1];
		mlt = $signed(xm) < $signed(ym);
		mle = !($signed(ym) < $signed(xm));
		priority if (!xn && yn) begin
			r = 1'b0;
		end else if (xn && !yn) begin
			r = 1'b1;
		end else if (xn && yn) begin
			priority if ($signed(xe) > $signed(ye)) begin
				r = 1'b1;
			end else if ($signed(xe) < $signed(ye)) begin
				r = 1'b0;
			end else begin
				r = strict ? mlt : mle;
			end
		end else if (xm == '0) begin
			r = strict ? (ym != '0) : 1'b1;
		end else begin
			priority if ($signed(xe) > $signed(ye)) begin
				r = 1'b0;
			end else if ($signed(xe) < $signed(ye)) begin
				r = 1'b1;
			end else begin
				r = strict ? mlt : mle;
			end
		end
		return r;
	endfunction

	// Stage 1: decode and operand preparation.
	logic [MW-1:0] ma, mb, mbp, mh1, ml1, absa, absb, trm;
	logic [EW-1:0] ea, eb, eh1, el1;
	logic          a_gt, eq_add, mz;
	logic [SW-1:0] fl;
	logic [1:0]    sel1;
	wmfa_pkg::out_beat_t res1;

	always_comb begin
		ma     = req.a_mantissa;
		mb     = req.b_mantissa;
		ea     = req.a_exponent;
		eb     = req.b_exponent;
		mbp    = (req.opcode == wmfa_pkg::OP_SUB) ? (MW'(0) - mb) : mb;
		a_gt   = $signed(ea) > $signed(eb);
		eq_add = (ea == eb) && (ma == mbp);
		eh1    = a_gt ? ea : eb;
		el1    = a_gt ? eb : ea;
		mh1    = a_gt ? ma : mbp;
		ml1    = a_gt ? mbp : ma;
		absa   = ma[MW-1] ? (MW'(0) - ma) : ma;
		absb   = mb[MW-1] ? (MW'(0) - mb) : mb;
		mz     = (ma == '0) || (mb == '0);
		fl     = SW'(MW - 2) - ea[SW-1:0];
		trm    = (ea > EW'(MW - 2)) ? ma : (ma & ({MW{1'b1}} << fl));
		res1   = '0;
		sel1   = SEL_FIX;
		unique case (req.opcode)
			wmfa_pkg::OP_ADD, wmfa_pkg::OP_SUB: begin
				if (eq_add) begin
					res1.r_exponent = ea + EW'(1);
					res1.r_mantissa = ma;
				end else begin
					sel1 = SEL_ADD;
				end
			end
			wmfa_pkg::OP_MUL: begin
				if (!mz) begin
					sel1 = SEL_MUL;
				end
			end
			wmfa_pkg::OP_DIV: begin
				priority if (ma != '0 && mb == '0) begin
					res1.status       = wmfa_pkg::ST_INF;
					res1.special_sign = ma[MW-1];
				end else if (ma == '0 && mb == '0) begin
					res1.status = wmfa_pkg::ST_NAN;
				end else if (ma != '0) begin
					sel1 = SEL_DIV;
				end else begin
					sel1 = SEL_FIX;
				end
			end
			wmfa_pkg::OP_LT: res1.compare_true = cmp_core(ea, ma, eb, mb, 1'b1);
			wmfa_pkg::OP_LE: res1.compare_true = cmp_core(ea, ma, eb, mb, 1'b0);
			wmfa_pkg::OP_GT: res1.compare_true = cmp_core(eb, mb, ea, ma, 1'b1);
			wmfa_pkg::OP_GE: res1.compare_true = cmp_core(eb, mb, ea, ma, 1'b0);
			wmfa_pkg::OP_TRUNC: begin
				if (!ea[EW-1]) begin
					res1.r_exponent = ea;
					res1.r_mantissa = trm;
				end
			end
			default: begin
				res1 = '0;
			end
		endcase
	end

	logic [1:0]          sel_s1;
	wmfa_pkg::out_beat_t res_s1;
	logic [EW-1:0]       eh_s1, dexp_s1, esum_s1, dexp_div_s1;
	logic [MW-1:0]       mh_s1, ml_s1, x_s1, y_s1;
	logic                mneg_s1;
	wmfa_pkg::div_t      div_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1      <= sel1;
			res_s1      <= res1;
			eh_s1       <= eh1;
			dexp_s1     <= eh1 - el1;
			mh_s1       <= mh1;
			ml_s1       <= ml1;
			x_s1        <= {absa[MW-2:0], 1'b0};
			y_s1        <= {absb[MW-2:0], 1'b0};
			mneg_s1     <= ma[MW-1] ^ mb[MW-1];
			esum_s1     <= ea + eb;
			dexp_div_s1 <= ea - eb;
			div_s1.rem  <= '0;
			div_s1.dvs  <= absb;
			div_s1.qd   <= {absa[MW-2:0], (MW + 1)'(0)};
		end
	end

	// Stage 2: alignment shift and partial products.
	logic              far2;
	logic [MW-1:0]     mlal2;
	logic [PLL_W-1:0]  pll2;
	logic [PMID_W-1:0] plh2, phl2;
	logic [PHH_W-1:0]  phh2;

	always_comb begin
		far2  = dexp_s1 >= EW'(MW);
		mlal2 = far2 ? '0 : MW'($signed(ml_s1) >>> dexp_s1[SW-1:0]);
		pll2  = PLL_W'(x_s1[HL-1:0]) * PLL_W'(y_s1[HL-1:0]);
		plh2  = PMID_W'(x_s1[HL-1:0]) * PMID_W'(y_s1[MW-1:HL]);
		phl2  = PMID_W'(x_s1[MW-1:HL]) * PMID_W'(y_s1[HL-1:0]);
		phh2  = PHH_W'(x_s1[MW-1:HL]) * PHH_W'(y_s1[MW-1:HL]);
	end

	logic [1:0]          sel_s2;
	wmfa_pkg::out_beat_t res_s2;
	logic [EW-1:0]       eh_s2, esum_s2, dexp_div_s2;
	logic [MW-1:0]       mh_s2, mlal_s2;
	logic [PLL_W-1:0]    pll_s2;
	logic [PMID_W-1:0]   plh_s2, phl_s2;
	logic [PHH_W-1:0]    phh_s2;
	logic                mneg_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2      <= sel_s1;
			res_s2      <= res_s1;
			eh_s2       <= eh_s1;
			mh_s2       <= mh_s1;
			mlal_s2     <= mlal2;
			pll_s2      <= pll2;
			plh_s2      <= plh2;
			phl_s2      <= phl2;
			phh_s2      <= phh2;
			mneg_s2     <= mneg_s1;
			esum_s2     <= esum_s1;
			dexp_div_s2 <= dexp_div_s1;
		end
	end

	// Stage 3: mantissa sum and middle partial-product sum.
	logic [1:0]          sel_s3;
	wmfa_pkg::out_beat_t res_s3;
	logic [EW-1:0]       eh_s3, esum_s3, dexp_div_s3;
	logic [MW-1:0]       sum_s3;
	logic                mixed_s3, negh_s3, mneg_s3;
	logic [PLL_W-1:0]    pll_s3;
	logic [PMID_W:0]     mid_s3;
	logic [PHH_W-1:0]    phh_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s3      <= sel_s2;
			res_s3      <= res_s2;
			eh_s3       <= eh_s2;
			sum_s3      <= mh_s2 + mlal_s2;
			mixed_s3    <= mh_s2[MW-1] ^ mlal_s2[MW-1];
			negh_s3     <= mh_s2[MW-1];
			pll_s3      <= pll_s2;
			mid_s3      <= (PMID_W + 1)'(plh_s2) + (PMID_W + 1)'(phl_s2);
			phh_s3      <= phh_s2;
			mneg_s3     <= mneg_s2;
			esum_s3     <= esum_s2;
			dexp_div_s3 <= dexp_div_s2;
		end
	end

	// Stage 4: leading-zero count of the sum and final product add.
	logic [MW-1:0] abs4;
	logic [QW-1:0] prod4;

	always_comb begin
		abs4  = sum_s3[MW-1] ? (MW'(0) - sum_s3) : sum_s3;
		prod4 = {phh_s3, pll_s3} + (QW'(mid_s3) << HL);
	end

	logic [1:0]          sel_s4;
	wmfa_pkg::out_beat_t res_s4;
	logic [EW-1:0]       eh_s4, esum_s4, dexp_div_s4;
	logic [MW-1:0]       sum_s4, up_s4;
	logic                mixed_s4, negh_s4, mneg_s4;
	logic [LW-1:0]       lz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s4      <= sel_s3;
			res_s4      <= res_s3;
			eh_s4       <= eh_s3;
			sum_s4      <= sum_s3;
			mixed_s4    <= mixed_s3;
			negh_s4     <= negh_s3;
			lz_s4       <= wmfa_pkg::clz_mant(abs4);
			up_s4       <= prod4[QW-1:MW];
			mneg_s4     <= mneg_s3;
			esum_s4     <= esum_s3;
			dexp_div_s4 <= dexp_div_s3;
		end
	end

	// Stage 5: renormalize the sum, place the product, pick the result.
	logic [EW-1:0]       are, mre;
	logic [MW-1:0]       arm, mmag, mrm;
	wmfa_pkg::out_beat_t res5;

	always_comb begin
		priority if (mixed_s4 && sum_s4 == '0) begin
			are = '0;
			arm = '0;
		end else if (mixed_s4 && lz_s4 == '0) begin
			are = eh_s4 + EW'(1);
			arm = {sum_s4[MW-1], sum_s4[MW-1:1]};
		end else if (mixed_s4) begin
			are = eh_s4 - EW'(lz_s4) + EW'(1);
			arm = sum_s4 << (lz_s4 - LW'(1));
		end else if (sum_s4[MW-1] != negh_s4) begin
			// Same-sign overflow: the lost carry is the operands' sign.
			are = eh_s4 + EW'(1);
			arm = {negh_s4, sum_s4[MW-1:1]};
		end else begin
			are = eh_s4;
			arm = sum_s4;
		end
		mmag = up_s4[MW-1] ? {1'b0, up_s4[MW-1:1]} : up_s4;
		mre  = esum_s4 + EW'(up_s4[MW-1]);
		mrm  = mneg_s4 ? (MW'(0) - mmag) : mmag;
		res5 = res_s4;
		unique case (sel_s4)
			SEL_ADD: begin
				res5.r_exponent = are;
				res5.r_mantissa = arm;
			end
			SEL_MUL: begin
				res5.r_exponent = mre;
				res5.r_mantissa = mrm;
			end
			SEL_FIX, SEL_DIV: begin
				res5 = res_s4;
			end
		endcase
	end

	wmfa_pkg::tail_t tail_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			tail_s5.use_div <= (sel_s4 == SEL_DIV);
			tail_s5.div_neg <= mneg_s4;
			tail_s5.div_exp <= dexp_div_s4;
			tail_s5.res     <= res5;
		end
	end

	assign tail     = tail_s5;
	assign div_init = div_s1;

endmodule

>>> sv/wmfa_back.sv
// Back end: quotient normalization and final result selection.
module wmfa_back (
	input  logic                 clk,
	input  logic                 en,
	input  wmfa_pkg::div_t       div_in,
	input  wmfa_pkg::tail_t      tail_in,
	output wmfa_pkg::out_beat_t  result
);
	localparam int MW = wmfa_pkg::MANT_W;
	localparam int EW = wmfa_pkg::EXP_W;
	localparam int LW = wmfa_pkg::LZ_W;
	localparam int QW = wmfa_pkg::QUO_W;
	localparam int CW = wmfa_pkg::QLZ_W;

	logic [QW-1:0]   q_s1;
	logic            hinz_s1;
	logic [LW-1:0]   lzh_s1, lzl_s1;
	wmfa_pkg::tail_t tail_s1;

	// First stage: leading-zero counts of both quotient halves.
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= div_in.qd;
			hinz_s1 <= div_in.qd[QW-1:MW] != '0;
			lzh_s1  <= wmfa_pkg::clz_mant(div_in.qd[QW-1:MW]);
			lzl_s1  <= wmfa_pkg::clz_mant(div_in.qd[MW-1:0]);
			tail_s1 <= tail_in;
		end
	end

	logic [CW-1:0]       c;
	logic [QW-1:0]       qn;
	logic [MW-1:0]       mag, rm;
	logic [EW-1:0]       re;
	wmfa_pkg::out_beat_t dres;

	// Second stage: shift the leading one to the top, then drop one bit.
	always_comb begin
		c   = hinz_s1 ? CW'(lzh_s1) : (CW'(MW) + CW'(lzl_s1));
		qn  = q_s1 << c;
		mag = {1'b0, qn[QW-1:MW+1]};
		rm  = tail_s1.div_neg ? (MW'(0) - mag) : mag;
		re  = tail_s1.div_exp + EW'(MW) - EW'(c) - (hinz_s1 ? EW'(2) : EW'(0));
		dres              = '0;
		dres.r_exponent   = re;
		dres.r_mantissa   = rm;
		dres.status       = wmfa_pkg::ST_NORMAL;
		result            = tail_s1.use_div ? dres : tail_s1.res;
	end

endmodule

>>> dv/tb_wide_mantissa_float_alu_core.sv
// Self-checking testbench for the wide-mantissa float ALU core.
module tb_wide_mantissa_float_alu_core;
	import wmfa_pkg::*;

	// The pipeline holds 131 beats and a stalled output can hold everything in
	// place, so the watchdog allows a long quiet stretch before it calls a hang.
	localparam int PIPE_LATENCY = 131;
	localparam int QUIET_LIMIT  = 20000;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	in_beat_t  req;
	logic      rsp_valid;
	logic      rsp_ready;
	out_beat_t rsp;

	// Results still owed by the block, oldest first.
	out_beat_t pending_results[$];
	int        mismatch_count;
	int        quiet_cycles;
	int        send_idle_pct;
	int        sink_stall_pct;

	wide_mantissa_float_alu_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Leading-zero count of a full mantissa; an all-zero word gives 64.
	function automatic int lead_zeros(input logic [63:0] x);
		for (int i = 63; i >= 0; i--) begin
			if (x[i]) begin
				return 63 - i;
			end
		end
		return 64;
	endfunction

	function automatic logic [63:0] mant_mag(input logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	// Arithmetic right shift that saturates to the sign for long distances.
	function automatic logic [63:0] mant_asr(input logic [63:0] x, input longint d);
		if (d <= 0) begin
			return x;
		end
		if (d >= 64) begin
			return {64{x[63]}};
		end
		return $signed(x) >>> d;
	endfunction

	// Adds b into a, where a carries the larger exponent; b gets aligned.
	function automatic void add_aligned(input longint ea, input logic [63:0] ma,
			input longint eb, input logic [63:0] mb,
			output longint re, output logic [63:0] rm);
		longint      gap;
		logic [63:0] s;
		int          lz;
		gap = ea - eb;
		mb = (gap >= 64) ? 64'd0 : mant_asr(mb, gap);
		s = ma + mb;
		if (ma[63] != mb[63]) begin
			if (s == 0) begin
				re = 0;
				rm = 0;
				return;
			end
			lz = lead_zeros(mant_mag(s));
			if (lz == 0) begin
				rm = mant_asr(s, 1);
				re = ea + 1;
			end else begin
				rm = s << (lz - 1);
				re = ea - (lz - 1);
			end
			return;
		end
		// Same signs that overflow keep the true carry as the new sign bit.
		if (s[63] != ma[63]) begin
			rm = {ma[63], s[63:1]};
			re = ea + 1;
			return;
		end
		re = ea;
		rm = s;
	endfunction

	// Ordering rule of the block: with both operands negative, a larger
	// exponent means a smaller value, and tied exponents compare mantissas.
	function automatic logic ordered_below(input longint ea, input logic [63:0] ma,
			input longint eb, input logic [63:0] mb, input logic strict);
		if (!ma[63] && mb[63]) begin
			return 1'b0;
		end
		if (ma[63] && !mb[63]) begin
			return 1'b1;
		end
		if (ma[63] && mb[63]) begin
			if (ea != eb) begin
				return ea > eb;
			end
			return strict ? ($signed(ma) < $signed(mb)) : !($signed(mb) < $signed(ma));
		end
		if (ma == 0) begin
			return strict ? (mb != 0) : 1'b1;
		end
		if (ea != eb) begin
			return ea < eb;
		end
		return strict ? ($signed(ma) < $signed(mb)) : !($signed(mb) < $signed(ma));
	endfunction

	// Computes the result beat that one request beat must produce.
	function automatic out_beat_t alu_result(input in_beat_t b);
		out_beat_t    r;
		longint       ea, eb, re;
		logic [63:0]  ma, mb, rm, x, y, up, low;
		logic [127:0] wide, quo;
		int           sh, lz;
		ea = longint'(b.a_exponent);
		eb = longint'(b.b_exponent);
		ma = b.a_mantissa;
		mb = b.b_mantissa;
		re = 0;
		rm = 0;
		r = '0;
		case (b.opcode)
			OP_ADD, OP_SUB: begin
				if (b.opcode == OP_SUB) begin
					mb = -mb;
				end
				if (ea == eb && ma == mb) begin
					re = ea + 1;
					rm = ma;
				end else if (ea > eb) begin
					add_aligned(ea, ma, eb, mb, re, rm);
				end else begin
					add_aligned(eb, mb, ea, ma, re, rm);
				end
			end
			OP_MUL: begin
				if (ma != 0 && mb != 0) begin
					x = mant_mag(ma) << 1;
					y = mant_mag(mb) << 1;
					wide = {64'd0, x} * {64'd0, y};
					up = wide[127:64];
					rm = up >> up[63];
					re = ea + eb + longint'(up[63]);
					if (ma[63] != mb[63]) begin
						rm = -rm;
					end
				end
			end
			OP_DIV: begin
				if (ma != 0 && mb == 0) begin
					r.status = ST_INF;
					r.special_sign = ma[63];
				end else if (ma == 0 && mb == 0) begin
					r.status = ST_NAN;
				end else if (ma != 0) begin
					wide = {64'd0, mant_mag(ma)} << 65;
					quo = wide / {64'd0, mant_mag(mb)};
					up = quo[127:64];
					low = quo[63:0];
					re = ea - eb;
					if (up != 0) begin
						sh = 64 - lead_zeros(up);
						wide = quo >> sh;
						rm = wide[63:0];
						re = re + sh - 2;
					end else begin
						lz = lead_zeros(low);
						rm = (lz >= 64) ? 64'd0 : (low << lz);
						re = re - lz;
					end
					rm = rm >> 1;
					if (ma[63] != mb[63]) begin
						rm = -rm;
					end
				end
			end
			OP_LT: r.compare_true = ordered_below(ea, ma, eb, mb, 1'b1);
			OP_LE: r.compare_true = ordered_below(ea, ma, eb, mb, 1'b0);
			OP_GT: r.compare_true = ordered_below(eb, mb, ea, ma, 1'b1);
			OP_GE: r.compare_true = ordered_below(eb, mb, ea, ma, 1'b0);
			OP_TRUNC: begin
				// Clears the fraction bits below the binary point; exponents past
				// the mantissa leave it whole, negative ones give zero.
				if (ea >= 0) begin
					re = ea;
					rm = (ea > 62) ? ma : (ma & ({64{1'b1}} << (62 - ea)));
				end
			end
			default: begin
			end
		endcase
		r.r_exponent = re[15:0];
		r.r_mantissa = rm;
		return r;
	endfunction

	// Sends one beat. Valid stays high between back-to-back beats; it only
	// drops when the sender decides to idle before the next one.
	task automatic send_beat(input in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		pending_results.insert(pending_results.size(), alu_result(b));
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input logic [15:0] ae,
			input logic [63:0] am, input logic [15:0] be, input logic [63:0] bm);
		in_beat_t b;
		b.opcode = op;
		b.a_exponent = ae;
		b.a_mantissa = am;
		b.b_exponent = be;
		b.b_mantissa = bm;
		send_beat(b);
	endtask

	// A normalized mantissa: leading one at bit 62, random sign and fraction.
	function automatic logic [63:0] norm_mant();
		logic [63:0] m;
		m = {2'b01, 30'($urandom), 32'($urandom)};
		return $urandom_range(1) ? -m : m;
	endfunction

	// Mostly normalized values, with zeros, extremes and raw words mixed in.
	function automatic logic [63:0] pick_mant();
		case ($urandom_range(15))
			0:       return 64'd0;
			1:       return 64'h8000_0000_0000_0000;
			2:       return {$urandom, $urandom};
			3:       return 64'h7fff_ffff_ffff_ffff;
			default: return norm_mant();
		endcase
	endfunction

	function automatic logic [15:0] pick_exp(input logic [15:0] near);
		case ($urandom_range(7))
			0:       return 16'($urandom);
			1:       return near;
			2:       return near + 16'($urandom_range(60, 70));
			default: return near + 16'($urandom_range(8)) - 16'd4;
		endcase
	endfunction

	task automatic drain_results();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	localparam logic [63:0] ONE_P = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ONE_N = 64'hc000_0000_0000_0000;
	localparam logic [63:0] M_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] M_MAX = 64'h7fff_ffff_ffff_ffff;

	// Equal operands, cancellation, overflow both ways and far alignment.
	task automatic test_add_sub_edges();
		send_op(OP_ADD, 16'd0, 64'd0, 16'd0, 64'd0);
		send_op(OP_ADD, 16'd5, ONE_P, 16'd5, ONE_P);
		send_op(OP_SUB, 16'd3, ONE_P, 16'd3, ONE_P);
		send_op(OP_ADD, 16'd1, M_MAX, 16'd0, M_MAX);
		send_op(OP_ADD, 16'd1, M_MIN, 16'd0, ONE_N);
		send_op(OP_ADD, 16'd100, ONE_P, 16'd20, ONE_N);
		send_op(OP_SUB, 16'h7fff, M_MAX, 16'h8000, M_MIN);
		send_op(OP_ADD, 16'd4, ONE_P, 16'd3, 64'hbfff_ffff_ffff_ffff);
	endtask

	// Zero and extreme operands in multiply; every divide special case.
	task automatic test_mul_div_specials();
		send_op(OP_MUL, 16'd2, 64'd0, 16'd7, ONE_P);
		send_op(OP_MUL, 16'h7fff, M_MIN, 16'h7fff, M_MIN);
		send_op(OP_MUL, 16'h8000, M_MAX, 16'hffff, ONE_N);
		send_op(OP_DIV, 16'd1, ONE_N, 16'd0, 64'd0);
		send_op(OP_DIV, 16'd1, ONE_P, 16'd0, 64'd0);
		send_op(OP_DIV, 16'd0, 64'd0, 16'd0, 64'd0);
		send_op(OP_DIV, 16'd9, 64'd0, 16'd2, ONE_P);
		send_op(OP_DIV, 16'd0, M_MIN, 16'd0, 64'd1);
		send_op(OP_DIV, 16'h8000, 64'd1, 16'h7fff, M_MAX);
	endtask

	// Each compare once, over two negatives, mixed signs and zero; then truncate
	// at both exponent ends and an unused opcode.
	task automatic test_compare_trunc();
		send_op(OP_LT, 16'd3, ONE_N, 16'd5, ONE_N);
		send_op(OP_LE, 16'd4, M_MIN, 16'd4, ONE_N);
		send_op(OP_GT, 16'd0, 64'd0, 16'd0, 64'd0);
		send_op(OP_GE, 16'd2, ONE_P, 16'd2, ONE_N);
		send_op(OP_TRUNC, 16'hffff, ONE_P, 16'd0, 64'd0);
		send_op(OP_TRUNC, 16'd63, ONE_N, 16'd0, 64'd0);
		send_op(OP_TRUNC, 16'd10, 64'h5a5a_a5a5_5a5a_a5a5, 16'd0, 64'd0);
		send_op(4'hf, 16'hffff, M_MAX, 16'hffff, M_MIN);
	endtask

	// Random mix of operations over mostly well-formed operands.
	task automatic test_random_ops(input int count);
		logic [OP_W-1:0] op;
		logic [15:0]     ae;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(19) == 0) ? OP_W'($urandom_range(15))
				: OP_W'($urandom_range(8));
			ae = pick_exp(16'($urandom_range(40)) - 16'd20);
			send_op(op, ae, pick_mant(), pick_exp(ae), pick_mant());
		end
	endtask

	// Checks each accepted result against the oldest expectation, and draws
	// the next ready. Both use values from before the edge, so no race.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < 10) begin
					$display("unexpected result beat %p", rsp);
				end
			end else begin
				want = pending_results.pop_front();
				if (rsp.r_exponent !== want.r_exponent || rsp.r_mantissa !== want.r_mantissa
						|| rsp.compare_true !== want.compare_true
						|| rsp.status !== want.status
						|| rsp.special_sign !== want.special_sign) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10) begin
						$display("result mismatch: expected %p, got %p", want, rsp);
					end
				end
			end
		end
		rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Any cycle that moves a beat on either side resets the watchdog.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb_wide_mantissa_float_alu_core: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_ready      = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 7;
		sink_stall_pct = 86;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_sub_edges();
		test_mul_div_specials();
		test_compare_trunc();
		test_random_ops(250);

		send_idle_pct  = 86;
		sink_stall_pct = 7;
		test_random_ops(270);

		send_idle_pct  = 0;
		sink_stall_pct = 0;
		test_random_ops(280);

		req_valid <= 1'b0;
		drain_results();
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("tb_wide_mantissa_float_alu_core: PASS");
		end else begin
			$display("tb_wide_mantissa_float_alu_core: FAIL");
		end
		$finish;
	end

endmodule
